// ===== rtl/core/mio_pkg.sv =====
// Shared constants, types and RAM request struct for the interval overlap unit.
// No dependencies; mio_sort, mio_sweep, the top level and the checker import this package.
package mio_pkg;

  // Store capacity and time width
  localparam int MAX_INTERVALS = 256;
  localparam int TIME_BITS     = 16;

  // Fixed port widths
  localparam int IN_BITS   = 16;
  localparam int PEAK_BITS = 9;

  // Derived widths: address into the store, and a count that can hold the capacity
  localparam int IDX_BITS = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_BITS = $clog2(MAX_INTERVALS + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // One write port and one read port of a store
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    time_t wdata;
    idx_t  raddr;
  } ram_req_t;

endpackage

// ===== rtl/core/mio_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mio_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register one read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mio_sort.sv =====
// Insertion sort engine over one store, driven through a RAM request struct.
// Depends on mio_pkg; the top level steers its requests to either store.
module mio_sort import mio_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  cnt_t     n,
  input  time_t    rdata,
  output ram_req_t req,
  output logic     done
);

  localparam logic [1:0] SO_IDLE = 2'd0;
  localparam logic [1:0] SO_LDX  = 2'd1;
  localparam logic [1:0] SO_CMP  = 2'd2;
  localparam logic [1:0] SO_PUT  = 2'd3;

  localparam cnt_t ONE = cnt_t'(1);
  localparam cnt_t TWO = cnt_t'(2);

  logic [1:0] state, state_next;
  cnt_t       k, k_next;
  cnt_t       m, m_next;
  time_t      x, x_next;
  logic       done_next;

  cnt_t k_plus, k_minus1, m_minus1, m_minus2;

  assign k_plus   = k + ONE;
  assign k_minus1 = k - ONE;
  assign m_minus1 = m - ONE;
  assign m_minus2 = m - TWO;

  // Sequence one key pick-up, the shifts, and the final placement
  always_comb begin
    state_next = state;
    k_next     = k;
    m_next     = m;
    x_next     = x;
    done_next  = 1'b0;
    req.we     = 1'b0;
    req.waddr  = m[IDX_BITS-1:0];
    req.wdata  = x;
    req.raddr  = '0;
    unique case (state)
      SO_IDLE: begin
        if (go) begin
          if (n < TWO) begin
            done_next = 1'b1;
          end else begin
            k_next     = ONE;
            req.raddr  = ONE[IDX_BITS-1:0];
            state_next = SO_LDX;
          end
        end
      end
      SO_LDX: begin
        // pick up the key and look at its left neighbor
        x_next     = rdata;
        m_next     = k;
        req.raddr  = k_minus1[IDX_BITS-1:0];
        state_next = SO_CMP;
      end
      SO_CMP: begin
        if (rdata > x) begin
          // shift the larger entry right
          req.we    = 1'b1;
          req.waddr = m[IDX_BITS-1:0];
          req.wdata = rdata;
          m_next    = m_minus1;
          if (m == ONE) begin
            state_next = SO_PUT;
          end else begin
            req.raddr = m_minus2[IDX_BITS-1:0];
          end
        end else begin
          state_next = SO_PUT;
        end
      end
      SO_PUT: begin
        req.we = 1'b1;
        if (k_plus == n) begin
          done_next  = 1'b1;
          state_next = SO_IDLE;
        end else begin
          k_next     = k_plus;
          req.raddr  = k_plus[IDX_BITS-1:0];
          state_next = SO_LDX;
        end
      end
      default: begin
        state_next = SO_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SO_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    k <= k_next;
    m <= m_next;
    x <= x_next;
  end

endmodule

// ===== rtl/core/mio_sweep.sv =====
// Merge walk over the sorted arrival and departure stores; tracks the peak count.
// Depends on mio_pkg; reads both stores through their read ports.
module mio_sweep import mio_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  go,
  input  cnt_t  n,
  input  logic  tie_rule,
  input  time_t a_data,
  input  time_t d_data,
  output idx_t  a_raddr,
  output idx_t  d_raddr,
  output logic  done,
  output cnt_t  best
);

  localparam logic SW_IDLE = 1'b0;
  localparam logic SW_EVAL = 1'b1;

  localparam cnt_t ONE = cnt_t'(1);

  typedef logic signed [CNT_BITS:0] run_t;

  logic state, state_next;
  cnt_t i, i_next;
  cnt_t j, j_next;
  run_t cur, cur_next;
  cnt_t best_next;
  logic done_next;

  logic take;
  run_t cur_inc;

  assign cur_inc = cur + run_t'(1);

  // Arrival goes first unless a departure is earlier, or equal under the rooms rule
  always_comb begin
    if (j >= n) begin
      take = 1'b1;
    end else if (tie_rule) begin
      take = a_data < d_data;
    end else begin
      take = a_data <= d_data;
    end
  end

  // Step one event per cycle, reading ahead at the next indices
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    cur_next   = cur;
    best_next  = best;
    done_next  = 1'b0;
    unique case (state)
      SW_IDLE: begin
        if (go) begin
          i_next    = '0;
          j_next    = '0;
          cur_next  = '0;
          best_next = '0;
          if (n == '0) begin
            done_next = 1'b1;
          end else begin
            state_next = SW_EVAL;
          end
        end
      end
      SW_EVAL: begin
        if (take) begin
          i_next   = i + ONE;
          cur_next = cur_inc;
          if (cur_inc > $signed({1'b0, best})) begin
            best_next = cur_inc[CNT_BITS-1:0];
          end
          if (i_next == n) begin
            done_next  = 1'b1;
            state_next = SW_IDLE;
          end
        end else begin
          j_next   = j + ONE;
          cur_next = cur - run_t'(1);
        end
      end
      default: begin
        state_next = SW_IDLE;
      end
    endcase
  end

  assign a_raddr = (state == SW_EVAL) ? i_next[IDX_BITS-1:0] : '0;
  assign d_raddr = (state == SW_EVAL) ? j_next[IDX_BITS-1:0] : '0;

  // Hold walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SW_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    i    <= i_next;
    j    <= j_next;
    cur  <= cur_next;
    best <= best_next;
  end

endmodule

// ===== rtl/core/max_interval_overlap_unit.sv =====
// Top level of the interval overlap unit: load sequencer, two stores, sort, walk.
// Depends on mio_pkg, mio_ram, mio_sort and mio_sweep.
//
// Use: drive one interval per item on arrival_time/departure_time with start high
// while busy is low; the item is taken at that clock edge. Set last on the final
// interval of a set; busy stays low while loading. Up to MAX_INTERVALS pairs are
// stored; later pairs are dropped and reported through overflow. A pair whose
// departure precedes its arrival sets pair_error.
// After the last item busy goes high. The arrival store is insertion-sorted,
// then the departure store, by the one sort engine. The merge walk follows.
// The result appears on peak_count/pair_error/overflow for one cycle with done
// high; it cannot be held off. In that same cycle busy is low again and the
// store count and flags are cleared for the next set.
// The user must write tie_mode through tie_mode_we only while the block is idle; the block does not enforce this.
// Reset (rst, synchronous) empties the store, clears the flags and tie mode.
module max_interval_overlap_unit import mio_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [IN_BITS-1:0]   arrival_time,
  input  logic [IN_BITS-1:0]   departure_time,
  input  logic                 last,
  input  logic                 tie_mode_we,
  input  logic                 tie_mode,
  output logic                 done,
  output logic [PEAK_BITS-1:0] peak_count,
  output logic                 pair_error,
  output logic                 overflow
);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SORT_A = 2'd1;
  localparam logic [1:0] ST_SORT_D = 2'd2;
  localparam logic [1:0] ST_SWEEP  = 2'd3;

  localparam cnt_t CAP = cnt_t'(MAX_INTERVALS);

  logic [1:0] state;
  cnt_t       count;
  logic       err_seen;
  logic       ovf_seen;
  logic       launch;
  logic       tie_rule;

  logic     accept;
  logic     room;
  time_t    a_in, d_in;
  ram_req_t a_req, d_req, sort_req;
  time_t    a_rdata, d_rdata, sort_rdata;
  logic     sort_done;
  idx_t     sw_a_raddr, sw_d_raddr;
  logic     sw_done;
  cnt_t     sw_best;

  assign busy   = (state != ST_LOAD);
  assign accept = start && !busy;
  assign room   = (count < CAP);
  assign a_in   = time_t'(arrival_time);
  assign d_in   = time_t'(departure_time);

  // Steer the store ports: input writes while loading, sorter or walk afterwards
  always_comb begin
    a_req.we    = accept && room;
    a_req.waddr = count[IDX_BITS-1:0];
    a_req.wdata = a_in;
    a_req.raddr = sw_a_raddr;
    d_req.we    = accept && room;
    d_req.waddr = count[IDX_BITS-1:0];
    d_req.wdata = d_in;
    d_req.raddr = sw_d_raddr;
    unique case (state)
      ST_SORT_A: a_req = sort_req;
      ST_SORT_D: d_req = sort_req;
      default: begin
      end
    endcase
  end

  assign sort_rdata = (state == ST_SORT_D) ? d_rdata : a_rdata;

  mio_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_INTERVALS)) u_arr_ram (
    .clk   (clk),
    .we    (a_req.we),
    .waddr (a_req.waddr),
    .wdata (a_req.wdata),
    .raddr (a_req.raddr),
    .rdata (a_rdata)
  );

  mio_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_INTERVALS)) u_dep_ram (
    .clk   (clk),
    .we    (d_req.we),
    .waddr (d_req.waddr),
    .wdata (d_req.wdata),
    .raddr (d_req.raddr),
    .rdata (d_rdata)
  );

  mio_sort u_sort (
    .clk   (clk),
    .rst   (rst),
    .go    (launch && (state == ST_SORT_A || state == ST_SORT_D)),
    .n     (count),
    .rdata (sort_rdata),
    .req   (sort_req),
    .done  (sort_done)
  );

  mio_sweep u_sweep (
    .clk      (clk),
    .rst      (rst),
    .go       (launch && (state == ST_SWEEP)),
    .n        (count),
    .tie_rule (tie_rule),
    .a_data   (a_rdata),
    .d_data   (d_rdata),
    .a_raddr  (sw_a_raddr),
    .d_raddr  (sw_d_raddr),
    .done     (sw_done),
    .best     (sw_best)
  );

  // Sequence load, both sorts and the walk; report and clear at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      err_seen <= 1'b0;
      ovf_seen <= 1'b0;
      launch   <= 1'b0;
      tie_rule <= 1'b0;
      done     <= 1'b0;
    end else begin
      done   <= 1'b0;
      launch <= 1'b0;
      if (tie_mode_we) begin
        tie_rule <= tie_mode;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (d_in < a_in) begin
              err_seen <= 1'b1;
            end
            if (room) begin
              count <= count + cnt_t'(1);
            end else begin
              ovf_seen <= 1'b1;
            end
            if (last) begin
              state  <= ST_SORT_A;
              launch <= 1'b1;
            end
          end
        end
        ST_SORT_A: begin
          if (sort_done) begin
            state  <= ST_SORT_D;
            launch <= 1'b1;
          end
        end
        ST_SORT_D: begin
          if (sort_done) begin
            state  <= ST_SWEEP;
            launch <= 1'b1;
          end
        end
        ST_SWEEP: begin
          if (sw_done) begin
            done       <= 1'b1;
            peak_count <= PEAK_BITS'(sw_best);
            pair_error <= err_seen;
            overflow   <= ovf_seen;
            count      <= '0;
            err_seen   <= 1'b0;
            ovf_seen   <= 1'b0;
            state      <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/mio_checker.sv =====
// Port-level checks of the interval overlap unit, bound to the top level.
// Depends on mio_pkg and max_interval_overlap_unit.
module mio_checker import mio_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 last,
  input logic                 done,
  input logic [PEAK_BITS-1:0] peak_count
);

  // Reset leaves the block ready with no result
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");

  // A result arrives only once the block is ready again
  a_done_ready: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while still busy");

  // A result is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Busy rises only after an accepted last item
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
      $rose(busy) |-> $past(start && last))
    else $error("busy without a last item");

  // A result carries a known peak count
  a_peak_known: assert property (@(posedge clk) disable iff (rst)
      done |-> !$isunknown(peak_count))
    else $error("unknown peak count on a result");

endmodule

bind max_interval_overlap_unit mio_checker u_mio_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .last       (last),
  .done       (done),
  .peak_count (peak_count)
);
